### rtl/windowed_dark_pixel_centroid_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dark pixel centroid block
// Two wrappers: one with reset gating, one checked at every edge.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_DARK_PIXEL_CENTROID_MACROS_SVH
`define WINDOWED_DARK_PIXEL_CENTROID_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while the reset is released.
`define WDPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define WDPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WDPC_ASSERT(lbl, clk, rstn, prop, msg)
`define WDPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/wdpc_pkg.sv
// ----------------------------------------------------------------------------
// wdpc_pkg
// Shared constants and register codes for the dark pixel centroid block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wdpc_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned APB_DATA_BITS  = 32;
  localparam int unsigned APB_ADDR_BITS  = 4;

  typedef enum logic [1:0] {
    REG_WIN_TOP,
    REG_WIN_BOTTOM,
    REG_WIN_LEFT,
    REG_WIN_RIGHT
  } reg_idx_e;

endpackage

### rtl/wdpc_front.sv
// ----------------------------------------------------------------------------
// wdpc_front
// Pixel intake: window test, dark-pixel sums and count, per-frame snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_dark_pixel_centroid_macros.svh"

module wdpc_front import wdpc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned EntryBits  = 3 * (3 * COORD_BITS) - COORD_BITS + 1
                                      + 2 * (COORD_BITS + FRAC_BITS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             pixel_value_i,
  input  logic [COORD_BITS-1:0]  pixel_row_i,
  input  logic [COORD_BITS-1:0]  pixel_col_i,
  input  logic                   frame_end_i,
  input  logic [COORD_BITS:0]    win_top_i,
  input  logic [COORD_BITS:0]    win_bottom_i,
  input  logic [COORD_BITS:0]    win_left_i,
  input  logic [COORD_BITS:0]    win_right_i,
  input  logic                   full_i,
  output logic                   push_o,
  output logic [EntryBits-1:0]   push_data_o
);

  localparam int unsigned RegBits  = COORD_BITS + 1;
  localparam int unsigned SpanBits = COORD_BITS + 2;
  localparam int unsigned SumBits  = 3 * COORD_BITS;
  localparam int unsigned CntBits  = 2 * COORD_BITS + 1;
  localparam int unsigned OutBits  = COORD_BITS + FRAC_BITS;

  logic [SumBits-1:0] col_sum_q, col_sum_d, col_sum_nx;
  logic [SumBits-1:0] row_sum_q, row_sum_d, row_sum_nx;
  logic [CntBits-1:0] cnt_q, cnt_d, cnt_nx;
  logic [OutBits-1:0] mid_x, mid_y;
  logic               hit;
  logic               accept;

  // Window shrunk by one border pixel: lo+1 <= pos <= hi-2
  function automatic logic in_span(input logic [COORD_BITS-1:0] pos,
                                   input logic [RegBits-1:0]    lo,
                                   input logic [RegBits-1:0]    hi);
    logic [SpanBits-1:0] p;
    logic [SpanBits-1:0] l;
    logic [SpanBits-1:0] h;
    p = SpanBits'(pos);
    l = SpanBits'(lo);
    h = SpanBits'(hi);
    return (p >= l + SpanBits'(1)) && (p + SpanBits'(2) <= h);
  endfunction

  // Truncated midpoint in fixed point, saturated to the field
  function automatic logic [OutBits-1:0] mid_fixed(input logic [RegBits-1:0] a,
                                                   input logic [RegBits-1:0] b);
    logic [SpanBits-1:0] s;
    logic [RegBits-1:0]  half;
    s    = SpanBits'(a) + SpanBits'(b);
    half = s[SpanBits-1:1];
    if (half[COORD_BITS]) begin
      return '1;
    end
    return OutBits'(half[COORD_BITS-1:0]) << FRAC_BITS;
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && frame_end_i;

  // Count saturates at 2^(2*COORD_BITS): the top bit marks the cap
  assign hit = (pixel_value_i == '0) && !cnt_q[CntBits-1]
               && in_span(pixel_row_i, win_top_i, win_bottom_i)
               && in_span(pixel_col_i, win_left_i, win_right_i);

  assign col_sum_nx = col_sum_q + (hit ? SumBits'(pixel_col_i) : '0);
  assign row_sum_nx = row_sum_q + (hit ? SumBits'(pixel_row_i) : '0);
  assign cnt_nx     = cnt_q + (hit ? CntBits'(1) : '0);

  assign mid_x = mid_fixed(win_left_i, win_right_i);
  assign mid_y = mid_fixed(win_top_i, win_bottom_i);

  assign push_data_o = {col_sum_nx, row_sum_nx, cnt_nx, mid_x, mid_y};

  always_comb begin
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    cnt_d     = cnt_q;
    if (accept) begin
      if (frame_end_i) begin
        col_sum_d = '0;
        row_sum_d = '0;
        cnt_d     = '0;
      end else begin
        col_sum_d = col_sum_nx;
        row_sum_d = row_sum_nx;
        cnt_d     = cnt_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sum_q <= '0;
      row_sum_q <= '0;
      cnt_q     <= '0;
    end else begin
      col_sum_q <= col_sum_d;
      row_sum_q <= row_sum_d;
      cnt_q     <= cnt_d;
    end
  end

  `WDPC_ASSERT(a_clear_after_frame, clk_i, rst_ni, push_o |=> (cnt_q == '0 && col_sum_q == '0 && row_sum_q == '0), "sums not cleared after frame end")
  `WDPC_ASSERT_ALWAYS(a_cnt_cap, clk_i, !rst_ni || !cnt_q[CntBits-1] || (cnt_q[CntBits-2:0] == '0), "dark count beyond cap")

endmodule

### rtl/wdpc_queue.sv
// ----------------------------------------------------------------------------
// wdpc_queue
// Short FIFO of frame snapshots between the intake and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_dark_pixel_centroid_macros.svh"

module wdpc_queue import wdpc_pkg::*; #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   ent_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == CntBits'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `WDPC_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "snapshot pushed into full queue")
  `WDPC_ASSERT_ALWAYS(a_cnt_range, clk_i, !rst_ni || (cnt_q <= CntBits'(Depth)), "queue fill out of range")

endmodule

### rtl/wdpc_back.sv
// ----------------------------------------------------------------------------
// wdpc_back
// Per-frame result: two restoring dividers in step, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_dark_pixel_centroid_macros.svh"

module wdpc_back import wdpc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned EntryBits  = 3 * (3 * COORD_BITS) - COORD_BITS + 1
                                      + 2 * (COORD_BITS + FRAC_BITS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  logic [EntryBits-1:0]    q_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_x_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_y_o,
  output logic [2*COORD_BITS:0]   dark_count_o,
  output logic                    region_empty_o
);

  localparam int unsigned SumBits  = 3 * COORD_BITS;
  localparam int unsigned CntBits  = 2 * COORD_BITS + 1;
  localparam int unsigned RemBits  = 2 * COORD_BITS;
  localparam int unsigned QBits    = COORD_BITS + FRAC_BITS;
  localparam int unsigned StepBits = $clog2(QBits);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [RemBits-1:0] rem;
    logic [QBits-1:0]   sh;
  } div_t;

  state_e              state_q;
  logic [StepBits-1:0] step_q;
  logic [RemBits-1:0]  rem_x_q, rem_y_q;
  logic [QBits-1:0]    sh_x_q, sh_y_q;
  logic [CntBits-1:0]  div_q;
  logic                empty_q;
  logic                out_valid_q;

  logic [SumBits-1:0]  e_col_sum, e_row_sum;
  logic [CntBits-1:0]  e_cnt;
  logic [QBits-1:0]    e_mid_x, e_mid_y;
  div_t                nx_x, nx_y;

  assign {e_col_sum, e_row_sum, e_cnt, e_mid_x, e_mid_y} = q_data_i;

  // Shift register feeds dividend bits out at the top, quotient bits in
  // at the bottom; after QBits steps it holds the quotient.
  function automatic div_t div_step(input logic [RemBits-1:0] rem,
                                    input logic [QBits-1:0]   sh,
                                    input logic [CntBits-1:0] d);
    logic [CntBits-1:0] t;
    logic [CntBits:0]   diff;
    logic               ge;
    div_t               r;
    t     = {rem, sh[QBits-1]};
    diff  = {1'b0, t} - {1'b0, d};
    ge    = !diff[CntBits];
    r.rem = ge ? diff[RemBits-1:0] : t[RemBits-1:0];
    r.sh  = {sh[QBits-2:0], ge};
    return r;
  endfunction

  assign nx_x  = div_step(rem_x_q, sh_x_q, div_q);
  assign nx_y  = div_step(rem_y_q, sh_y_q, div_q);
  assign pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            if (e_cnt == '0) begin
              state_q     <= ST_OUT;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= ST_DIV;
              step_q  <= '0;
            end
          end
        end
        ST_DIV: begin
          step_q <= step_q + StepBits'(1);
          if (step_q == StepBits'(QBits - 1)) begin
            state_q     <= ST_OUT;
            out_valid_q <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      div_q   <= e_cnt;
      empty_q <= (e_cnt == '0);
      if (e_cnt == '0) begin
        sh_x_q <= e_mid_x;
        sh_y_q <= e_mid_y;
      end else begin
        // quotient fits QBits, so the top sum bits are already below the count
        rem_x_q <= e_col_sum[SumBits-1:COORD_BITS];
        rem_y_q <= e_row_sum[SumBits-1:COORD_BITS];
        sh_x_q  <= QBits'(e_col_sum[COORD_BITS-1:0]) << FRAC_BITS;
        sh_y_q  <= QBits'(e_row_sum[COORD_BITS-1:0]) << FRAC_BITS;
      end
    end else if (state_q == ST_DIV) begin
      rem_x_q <= nx_x.rem;
      rem_y_q <= nx_y.rem;
      sh_x_q  <= nx_x.sh;
      sh_y_q  <= nx_y.sh;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign centroid_x_o   = sh_x_q;
  assign centroid_y_o   = sh_y_q;
  assign dark_count_o   = div_q;
  assign region_empty_o = empty_q;

  `WDPC_ASSERT(a_rem_below_div, clk_i, rst_ni, (state_q == ST_DIV) |-> ((CntBits'(rem_x_q) < div_q) && (CntBits'(rem_y_q) < div_q)), "divider remainder not below count")
  `WDPC_ASSERT(a_empty_flag, clk_i, rst_ni, out_valid_o |-> (region_empty_o == (dark_count_o == '0)), "empty flag disagrees with count")
  `WDPC_ASSERT(a_valid_in_out, clk_i, rst_ni, out_valid_o == (state_q == ST_OUT), "result valid outside output state")
  `WDPC_ASSERT(a_div_entry, clk_i, rst_ni, ((state_q == ST_IDLE) && q_valid_i && (e_cnt != '0)) |=> ((state_q == ST_DIV) && (step_q == '0)), "divide not started on non-empty frame")

endmodule

### rtl/windowed_dark_pixel_centroid.sv
// ----------------------------------------------------------------------------
// windowed_dark_pixel_centroid
// Dark-pixel centroid over a configurable window of a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock: the window test and the running sums sit
// in a single intake stage, so in_ready_o stays high except while the
// two-entry snapshot queue is full, which holds off every pixel until the
// divider takes the oldest frame result. Each frame result is worked out by
// a restoring divider pair that yields one quotient bit per cycle; a frame
// with dark pixels goes from the queue through ST_DIV to out_valid_o, while an
// empty frame reaches out_valid_o in the cycle after it leaves the queue;
// either result then waits on out_ready_i. Frames shorter than the divide
// rely on the two-entry queue to absorb the backlog.
// Window registers sit at byte addresses 0, 4, 8 and 12 (top, bottom, left,
// right) and are read back unchanged; no clearing pass is needed after reset.
`timescale 1ns / 1ps

module windowed_dark_pixel_centroid import wdpc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [APB_ADDR_BITS-1:0]        paddr,
  input  logic [APB_DATA_BITS-1:0]        pwdata,
  output logic [APB_DATA_BITS-1:0]        prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      pixel_value_i,
  input  logic [COORD_BITS-1:0]           pixel_row_i,
  input  logic [COORD_BITS-1:0]           pixel_col_i,
  input  logic                            frame_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_x_o,
  output logic [COORD_BITS+FRAC_BITS-1:0] centroid_y_o,
  output logic [2*COORD_BITS:0]           dark_count_o,
  output logic                            region_empty_o
);

  localparam int unsigned RegBits   = COORD_BITS + 1;
  localparam int unsigned EntryBits = 2 * (3 * COORD_BITS) + 2 * COORD_BITS + 1
                                      + 2 * (COORD_BITS + FRAC_BITS);

  logic [RegBits-1:0]   win_top_q, win_bottom_q, win_left_q, win_right_q;
  reg_idx_e             reg_idx;
  logic                 cfg_wr;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 q_valid;
  logic [EntryBits-1:0] push_data;
  logic [EntryBits-1:0] q_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_top_q    <= '0;
      win_bottom_q <= RegBits'(1) << COORD_BITS;
      win_left_q   <= '0;
      win_right_q  <= RegBits'(1) << COORD_BITS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIN_TOP:    win_top_q    <= pwdata[RegBits-1:0];
        REG_WIN_BOTTOM: win_bottom_q <= pwdata[RegBits-1:0];
        REG_WIN_LEFT:   win_left_q   <= pwdata[RegBits-1:0];
        REG_WIN_RIGHT:  win_right_q  <= pwdata[RegBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIN_TOP:    prdata = APB_DATA_BITS'(win_top_q);
      REG_WIN_BOTTOM: prdata = APB_DATA_BITS'(win_bottom_q);
      REG_WIN_LEFT:   prdata = APB_DATA_BITS'(win_left_q);
      REG_WIN_RIGHT:  prdata = APB_DATA_BITS'(win_right_q);
      default:        prdata = '0;
    endcase
  end

  wdpc_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .EntryBits  (EntryBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .frame_end_i   (frame_end_i),
    .win_top_i     (win_top_q),
    .win_bottom_i  (win_bottom_q),
    .win_left_i    (win_left_q),
    .win_right_i   (win_right_q),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  wdpc_queue #(
    .Width (EntryBits),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  wdpc_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .EntryBits  (EntryBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .dark_count_o   (dark_count_o),
    .region_empty_o (region_empty_o)
  );

endmodule

### tb/wdpc_centroid_checker.sv
// ----------------------------------------------------------------------------
// wdpc_centroid_checker
// Watches the pixel, result and register ports of the dark pixel centroid
// block, keeps its own copy of the window and running sums, and compares
// every result transaction against the centroid predicted for that frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdpc_centroid_checker import wdpc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [APB_ADDR_BITS-1:0]        paddr,
  input  logic [APB_DATA_BITS-1:0]        pwdata,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      pixel_value_i,
  input  logic [COORD_BITS-1:0]           pixel_row_i,
  input  logic [COORD_BITS-1:0]           pixel_col_i,
  input  logic                            frame_end_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [COORD_BITS+FRAC_BITS-1:0] centroid_x_i,
  input  logic [COORD_BITS+FRAC_BITS-1:0] centroid_y_i,
  input  logic [2*COORD_BITS:0]           dark_count_i,
  input  logic                            region_empty_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o
);

  localparam int unsigned     REG_BITS   = COORD_BITS + 1;
  localparam int unsigned     OUT_BITS   = COORD_BITS + FRAC_BITS;
  localparam int unsigned     COUNT_BITS = 2 * COORD_BITS + 1;
  localparam int unsigned     SUM_BITS   = 3 * COORD_BITS;
  localparam longint unsigned OUT_MAX    = (64'd1 << OUT_BITS) - 1;
  localparam longint unsigned HIT_CAP    = 64'd1 << (2 * COORD_BITS);

  typedef struct packed {
    logic [OUT_BITS-1:0]   x;
    logic [OUT_BITS-1:0]   y;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
  } centroid_t;

  logic [REG_BITS-1:0]   win_top, win_bottom, win_left, win_right;
  logic [SUM_BITS-1:0]   col_acc, row_acc;
  logic [COUNT_BITS-1:0] dark_hits;
  centroid_t             centroid_q[$];
  centroid_t             seen, wanted;
  int unsigned           mismatch_total = 0;

  function automatic bit in_window_span(longint unsigned pos, longint unsigned lo,
                                        longint unsigned hi);
    return (pos >= lo + 1) && (pos + 2 <= hi);
  endfunction

  function automatic logic [OUT_BITS-1:0] saturate_fixed(longint unsigned v);
    return (v > OUT_MAX) ? OUT_BITS'(OUT_MAX) : OUT_BITS'(v);
  endfunction

  // Mean of the dark pixels, or the window midpoint when none were counted
  function automatic centroid_t frame_centroid();
    centroid_t       c;
    longint unsigned hits;
    hits = 64'(dark_hits);
    if (hits != 0) begin
      c.x     = saturate_fixed((64'(col_acc) << FRAC_BITS) / hits);
      c.y     = saturate_fixed((64'(row_acc) << FRAC_BITS) / hits);
      c.empty = 1'b0;
    end else begin
      c.x     = saturate_fixed(((64'(win_left) + 64'(win_right)) >> 1) << FRAC_BITS);
      c.y     = saturate_fixed(((64'(win_top) + 64'(win_bottom)) >> 1) << FRAC_BITS);
      c.empty = 1'b1;
    end
    c.count = dark_hits;
    return c;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_total++;
    $display("[%0t] centroid mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_top    = '0;
      win_bottom = REG_BITS'(1 << COORD_BITS);
      win_left   = '0;
      win_right  = REG_BITS'(1 << COORD_BITS);
      col_acc    = '0;
      row_acc    = '0;
      dark_hits  = '0;
      centroid_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{centroid_x_i, centroid_y_i, dark_count_i, region_empty_i};
        if (centroid_q.size() == 0) begin
          note_mismatch($sformatf("result with no frame waiting: x=%0d y=%0d n=%0d e=%0b",
                                  seen.x, seen.y, seen.count, seen.empty));
        end else begin
          wanted = centroid_q.pop_front();
          check_field("centroid_x", 32'(seen.x), 32'(wanted.x));
          check_field("centroid_y", 32'(seen.y), 32'(wanted.y));
          check_field("dark_count", 32'(seen.count), 32'(wanted.count));
          check_field("region_empty", 32'(seen.empty), 32'(wanted.empty));
        end
      end

      if (in_valid_i && in_ready_i) begin
        // past the hit cap further dark pixels are dropped until the frame end
        if (pixel_value_i == '0 && dark_hits < HIT_CAP &&
            in_window_span(64'(pixel_row_i), 64'(win_top), 64'(win_bottom)) &&
            in_window_span(64'(pixel_col_i), 64'(win_left), 64'(win_right))) begin
          row_acc   = row_acc + SUM_BITS'(pixel_row_i);
          col_acc   = col_acc + SUM_BITS'(pixel_col_i);
          dark_hits = dark_hits + COUNT_BITS'(1);
        end
        if (frame_end_i) begin
          centroid_q.insert(centroid_q.size(), frame_centroid());
          col_acc   = '0;
          row_acc   = '0;
          dark_hits = '0;
        end
      end

      // a register write only affects the pixels after it
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_WIN_TOP:    win_top    = pwdata[REG_BITS-1:0];
          REG_WIN_BOTTOM: win_bottom = pwdata[REG_BITS-1:0];
          REG_WIN_LEFT:   win_left   = pwdata[REG_BITS-1:0];
          REG_WIN_RIGHT:  win_right  = pwdata[REG_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending_o <= centroid_q.size();
    errors_o  <= mismatch_total;
  end

endmodule

### tb/windowed_dark_pixel_centroid_tb.sv
// ----------------------------------------------------------------------------
// windowed_dark_pixel_centroid_tb
// Drives pixel frames through the centroid block over a series of window
// settings and idling patterns, with one long output hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_dark_pixel_centroid_tb;
  import wdpc_pkg::*;

  localparam int unsigned COORD_BITS    = COORD_BITS_DEF;
  localparam int unsigned FRAC_BITS     = FRAC_BITS_DEF;
  localparam int unsigned REG_BITS      = COORD_BITS + 1;
  localparam int          COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int          WIN_MAX       = 1 << COORD_BITS;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned NUM_PHASES    = 8;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            psel           = 1'b0;
  logic                            penable        = 1'b0;
  logic                            pwrite         = 1'b0;
  logic [APB_ADDR_BITS-1:0]        paddr          = '0;
  logic [APB_DATA_BITS-1:0]        pwdata         = '0;
  logic [APB_DATA_BITS-1:0]        prdata;
  logic                            pready;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic [7:0]                      pixel_value_i  = '0;
  logic [COORD_BITS-1:0]           pixel_row_i    = '0;
  logic [COORD_BITS-1:0]           pixel_col_i    = '0;
  logic                            frame_end_i    = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b0;
  logic [COORD_BITS+FRAC_BITS-1:0] centroid_x_o;
  logic [COORD_BITS+FRAC_BITS-1:0] centroid_y_o;
  logic [2*COORD_BITS:0]           dark_count_o;
  logic                            region_empty_o;

  int unsigned mismatches;
  int unsigned frames_pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_orders   = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  // window as last written, used only to aim the random pixels
  int          win_top = 0, win_bottom = WIN_MAX, win_left = 0, win_right = WIN_MAX;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  windowed_dark_pixel_centroid #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .centroid_x_o  (centroid_x_o),
    .centroid_y_o  (centroid_y_o),
    .dark_count_o  (dark_count_o),
    .region_empty_o(region_empty_o)
  );

  wdpc_centroid_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .frame_end_i   (frame_end_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .centroid_x_i  (centroid_x_o),
    .centroid_y_i  (centroid_y_o),
    .dark_count_i  (dark_count_o),
    .region_empty_i(region_empty_o),
    .errors_o      (mismatches),
    .pending_o     (frames_pending)
  );

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_orders) begin
      out_ready_i <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("windowed_dark_pixel_centroid_tb: errors");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] value, int row, int col, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= value;
    pixel_row_i   <= COORD_BITS'(row);
    pixel_col_i   <= COORD_BITS'(col);
    frame_end_i   <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Mostly inside or on the border of the window, some anywhere in the frame
  function automatic int pick_coord(int lo, int hi);
    int a, b, e;
    a = ((lo < hi) ? lo : hi) - 1;
    b = (lo < hi) ? hi : lo;
    if (a < 0) a = 0;
    if (b > COORD_MAX) b = COORD_MAX;
    e = (int'($urandom_range(1)) ? lo : hi - 2) + int'($urandom_range(1));
    if (e < 0) e = 0;
    if (e > COORD_MAX) e = COORD_MAX;
    case ($urandom_range(9))
      0, 1:    return int'($urandom_range(COORD_MAX));
      2, 3:    return e;
      default: return int'($urandom_range(b, a));
    endcase
  endfunction

  task automatic send_random_frames(int unsigned items);
    int unsigned sent, len;
    logic [7:0]  value;
    sent = 0;
    while (sent < items) begin
      // short frames pile up behind the divider
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
      for (int unsigned i = 0; i < len; i++) begin
        value = ($urandom_range(99) < 55) ? 8'd0 : 8'($urandom_range(1, 255));
        send_pixel(value, pick_coord(win_top, win_bottom), pick_coord(win_left, win_right),
                   i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, int value);
    logic [APB_DATA_BITS-1:0] word;
    word                 = $urandom;
    word[REG_BITS-1:0]   = REG_BITS'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_window(int t, int b, int l, int r);
    reg_write(REG_WIN_TOP, t);
    reg_write(REG_WIN_BOTTOM, b);
    reg_write(REG_WIN_LEFT, l);
    reg_write(REG_WIN_RIGHT, r);
    win_top    = t;
    win_bottom = b;
    win_left   = l;
    win_right  = r;
  endtask

  initial begin
    int t, b, l, r;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: rows and columns 1 to 4094 count
    send_pixel(8'd0, 0, 0, 1'b1);                 // border pixel only, empty frame
    send_pixel(8'd0, 1, 1, 1'b0);                 // first counted corner
    send_pixel(8'd0, COORD_MAX - 1, COORD_MAX - 1, 1'b0);
    send_pixel(8'd0, COORD_MAX, 100, 1'b0);       // last row, excluded
    send_pixel(8'd0, 100, COORD_MAX, 1'b0);       // last column, excluded
    send_pixel(8'd0, 0, 50, 1'b0);
    send_pixel(8'hff, 10, 10, 1'b0);
    send_pixel(8'd1, 20, 20, 1'b0);
    send_pixel(8'h80, 30, 30, 1'b0);
    send_pixel(8'd0, 2000, 3000, 1'b1);           // frame end pixel is counted
    send_pixel(8'd0, COORD_MAX - 1, COORD_MAX - 1, 1'b0);
    send_pixel(8'd0, COORD_MAX - 1, COORD_MAX - 1, 1'b0);
    send_pixel(8'd0, COORD_MAX - 1, COORD_MAX - 1, 1'b1);
    send_pixel(8'd7, 5, 5, 1'b1);                 // bright end, nothing dark
    send_pixel(8'd0, 1, COORD_MAX - 1, 1'b1);     // one-pixel frame
    send_pixel(8'd0, COORD_MAX - 1, 1, 1'b0);
    send_pixel(8'd0, 1, 2, 1'b1);                 // half-pixel fractions
    send_pixel(8'd0, 1, 1, 1'b0);
    send_pixel(8'd0, 1, 1, 1'b0);
    send_pixel(8'd0, 2, 2, 1'b1);                 // truncated thirds
    send_random_frames(PHASE_ITEMS);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_window(10, 40, 20, 60);
        1: set_window(WIN_MAX, WIN_MAX, WIN_MAX, WIN_MAX);  // midpoint saturates
        2: set_window(0, 3, WIN_MAX - 3, WIN_MAX);          // single row and column
        3: set_window(100, 50, 0, 2);                       // inverted and degenerate
        6: begin
          t = $urandom_range(WIN_MAX - 20);
          l = $urandom_range(WIN_MAX - 20);
          set_window(t, t + int'($urandom_range(20)), l, l + int'($urandom_range(20)));
        end
        7: set_window(0, WIN_MAX, 0, WIN_MAX);
        default: begin
          t = $urandom_range(WIN_MAX);
          b = $urandom_range(WIN_MAX);
          l = $urandom_range(WIN_MAX);
          r = $urandom_range(WIN_MAX);
          set_window((t < b) ? t : b, (t < b) ? b : t, (l < r) ? l : r, (l < r) ? r : l);
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 57; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 57; end
        default: begin send_idle_pct = 27; stall_pct <= 27; end
      endcase
      send_random_frames(PHASE_ITEMS);
      wait_idle();
    end

    // back-to-back frame ends against a stalled output fill the snapshot queue
    send_idle_pct = 0;
    stall_pct   <= 0;
    hold_orders <= hold_orders + 1;
    repeat (40) send_pixel(8'd0, int'($urandom_range(1, COORD_MAX - 1)),
                           int'($urandom_range(1, COORD_MAX - 1)), 1'b1);
    wait_idle();

    if (mismatches == 0) begin
      $display("windowed_dark_pixel_centroid_tb: clean");
    end else begin
      $display("windowed_dark_pixel_centroid_tb: errors");
    end
    $finish;
  end

endmodule
